// ===== rtl/core/c6502alu_pkg.sv =====
// Shared types, operation codes and helpers for the 6502 ALU and flag unit.
`timescale 1ns / 1ps

package c6502alu_pkg;

    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned S_TDATA_W  = 16;
    localparam int unsigned M_TDATA_W  = 48;

    // Configuration register indexes (word address bit 2).
    localparam logic REG_ANE_CONSTANT = 1'b0;

    localparam logic [7:0] ANE_CONSTANT_RESET = 8'hEE;
    localparam logic [7:0] LXA_MAGIC          = 8'hEE;

    typedef enum logic [5:0] {
        OP_LDA = 6'd0,  OP_LDX = 6'd1,  OP_LDY = 6'd2,  OP_TAX = 6'd3,
        OP_TAY = 6'd4,  OP_TXA = 6'd5,  OP_TYA = 6'd6,  OP_TSX = 6'd7,
        OP_TXS = 6'd8,  OP_ORA = 6'd9,  OP_AND = 6'd10, OP_EOR = 6'd11,
        OP_BIT = 6'd12, OP_ASL_A = 6'd13, OP_ASL_M = 6'd14, OP_LSR_A = 6'd15,
        OP_LSR_M = 6'd16, OP_ROL_A = 6'd17, OP_ROL_M = 6'd18, OP_ROR_A = 6'd19,
        OP_ROR_M = 6'd20, OP_INC = 6'd21, OP_DEC = 6'd22, OP_INX = 6'd23,
        OP_INY = 6'd24, OP_DEX = 6'd25, OP_DEY = 6'd26, OP_ADC = 6'd27,
        OP_SBC = 6'd28, OP_CMP = 6'd29, OP_CPX = 6'd30, OP_CPY = 6'd31,
        OP_SEC = 6'd32, OP_CLC = 6'd33, OP_SEI = 6'd34, OP_CLI = 6'd35,
        OP_SED = 6'd36, OP_CLD = 6'd37, OP_CLV = 6'd38, OP_PHP = 6'd39,
        OP_PLP = 6'd40, OP_LAX = 6'd41, OP_ANC = 6'd42, OP_SBX = 6'd43,
        OP_ARR = 6'd44, OP_XAA = 6'd45, OP_LXA = 6'd46, OP_LAS = 6'd47
    } cmd_t;

    typedef struct packed {
        logic n;
        logic v;
        logic b;
        logic d;
        logic i;
        logic z;
        logic c;
    } flags_t;

    typedef struct packed {
        logic [7:0] a;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] sp;
        flags_t     flags;
    } arch_t;

    typedef struct packed {
        arch_t      arch;
        logic [7:0] result;
    } alu_out_t;

    // NV1BDIZC with bits 4 and 5 forced high.
    function automatic logic [7:0] status_byte(input flags_t f);
        return {f.n, f.v, 2'b11, f.d, f.i, f.z, f.c};
    endfunction

endpackage

// ===== rtl/core/c6502alu_apb.sv =====
// APB register block holding the XAA magic constant.
`timescale 1ns / 1ps

module c6502alu_apb
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [c6502alu_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [c6502alu_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [c6502alu_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                   pready,
    output logic [7:0]                             ane_constant
);

    logic [7:0] ane_reg;
    logic [7:0] ane_next;
    logic       wr_hit;

    assign pready = 1'b1;
    assign wr_hit = psel && penable && pwrite
                    && (paddr[2] == c6502alu_pkg::REG_ANE_CONSTANT);

    always_comb
    begin
        ane_next = ane_reg;
        if (wr_hit)
        begin
            ane_next = pwdata[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ane_reg <= c6502alu_pkg::ANE_CONSTANT_RESET;
        end
        else
        begin
            ane_reg <= ane_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == c6502alu_pkg::REG_ANE_CONSTANT)
        begin
            prdata = {{(c6502alu_pkg::APB_DATA_W - 8){1'b0}}, ane_reg};
        end
    end

    assign ane_constant = ane_reg;

endmodule

// ===== rtl/core/c6502alu_alu.sv =====
// Combinational execute logic: next register/flag state and result byte for one operation.
`timescale 1ns / 1ps

module c6502alu_alu
(
    input  c6502alu_pkg::arch_t    cur,
    input  logic [5:0]             command,
    input  logic [7:0]             operand,
    input  logic [7:0]             ane_constant,
    output c6502alu_pkg::alu_out_t nxt
);

    function automatic c6502alu_pkg::flags_t with_zn(input c6502alu_pkg::flags_t f,
                                                    input logic [7:0] b);
        c6502alu_pkg::flags_t r;
        r   = f;
        r.z = (b == 8'h00);
        r.n = b[7];
        return r;
    endfunction

    function automatic logic [8:0] sub9(input logic [7:0] r, input logic [7:0] v);
        return {1'b0, r} - {1'b0, v};
    endfunction

    logic       c_in;
    logic [7:0] a;
    logic [7:0] v;

    assign c_in = cur.flags.c;
    assign a    = cur.a;
    assign v    = operand;

    // ADC, binary or with decimal nibble fixes
    logic [5:0] adc_lo;
    logic [9:0] adc_t;
    always_comb
    begin
        adc_lo = {2'b00, a[3:0]} + {2'b00, v[3:0]} + {5'b0, c_in};
        adc_t  = {2'b00, a} + {2'b00, v} + {9'b0, c_in};
        if (cur.flags.d)
        begin
            if (adc_lo > 6'd9)
            begin
                adc_lo = adc_lo + 6'd6;
            end
            adc_t = {4'b0, adc_lo} + {2'b00, a[7:4], 4'b0} + {2'b00, v[7:4], 4'b0};
            if (adc_t[8:4] > 5'd9)
            begin
                adc_t = adc_t + 10'h060;
            end
        end
    end

    // SBC, sixteen-bit wraparound as in the borrow chain
    logic [15:0] sbc_t;
    logic        borrow;
    assign borrow = ~c_in;
    always_comb
    begin
        sbc_t = {8'b0, a} - {8'b0, v} - {15'b0, borrow};
        if (cur.flags.d)
        begin
            sbc_t = {12'b0, a[3:0]} - {12'b0, v[3:0]} - {15'b0, borrow};
            if (sbc_t[4])
            begin
                sbc_t = {12'b0, sbc_t[3:0] - 4'd6}
                        | ({8'b0, a[7:4], 4'b0} - {8'b0, v[7:4], 4'b0} - 16'h0010);
            end
            else
            begin
                sbc_t = {12'b0, sbc_t[3:0]}
                        | ({8'b0, a[7:4], 4'b0} - {8'b0, v[7:4], 4'b0});
            end
            if (sbc_t[8])
            begin
                sbc_t = sbc_t - 16'h0060;
            end
        end
    end

    // ARR: AND then rotate right through carry, with decimal fixes
    logic [7:0] arr_and;
    logic [7:0] arr_sh;
    logic [7:0] arr_res;
    logic [4:0] arr_lo_sum;
    logic [4:0] arr_hi_sum;
    logic       arr_hi_fix;
    always_comb
    begin
        arr_and    = a & v;
        arr_sh     = {c_in, arr_and[7:1]};
        arr_lo_sum = {1'b0, arr_and[3:0]} + {4'b0, arr_and[0]};
        arr_hi_sum = {1'b0, arr_and[7:4]} + {4'b0, arr_and[4]};
        arr_hi_fix = (arr_hi_sum > 5'd5);
        arr_res    = arr_sh;
        if (arr_lo_sum > 5'd5)
        begin
            arr_res[3:0] = arr_res[3:0] + 4'd6;
        end
        if (arr_hi_fix)
        begin
            arr_res[7:4] = arr_res[7:4] + 4'd6;
        end
    end

    logic [8:0] cmp_a;
    logic [8:0] cmp_x;
    logic [8:0] cmp_y;
    logic [8:0] cmp_ax;
    logic [7:0] rol_src;
    logic [7:0] ror_src;
    logic [7:0] shl_src;
    logic [7:0] shr_src;

    assign cmp_a  = sub9(a, v);
    assign cmp_x  = sub9(cur.x, v);
    assign cmp_y  = sub9(cur.y, v);
    assign cmp_ax = sub9(a & cur.x, v);

    always_comb
    begin
        c6502alu_pkg::arch_t st;
        logic [7:0]          res;
        logic                flag_op;
        logic [7:0]          t8;

        st      = cur;
        res     = 8'h00;
        flag_op = 1'b0;
        t8      = 8'h00;
        shl_src = a;
        shr_src = a;
        rol_src = a;
        ror_src = a;

        case (command)
            c6502alu_pkg::OP_LDA:
            begin
                st.a = v; st.flags = with_zn(st.flags, v); res = v;
            end
            c6502alu_pkg::OP_LDX:
            begin
                st.x = v; st.flags = with_zn(st.flags, v); res = v;
            end
            c6502alu_pkg::OP_LDY:
            begin
                st.y = v; st.flags = with_zn(st.flags, v); res = v;
            end
            c6502alu_pkg::OP_TAX:
            begin
                st.x = a; st.flags = with_zn(st.flags, a); res = a;
            end
            c6502alu_pkg::OP_TAY:
            begin
                st.y = a; st.flags = with_zn(st.flags, a); res = a;
            end
            c6502alu_pkg::OP_TXA:
            begin
                st.a = cur.x; st.flags = with_zn(st.flags, cur.x); res = cur.x;
            end
            c6502alu_pkg::OP_TYA:
            begin
                st.a = cur.y; st.flags = with_zn(st.flags, cur.y); res = cur.y;
            end
            c6502alu_pkg::OP_TSX:
            begin
                st.x = cur.sp; st.flags = with_zn(st.flags, cur.sp); res = cur.sp;
            end
            c6502alu_pkg::OP_TXS:
            begin
                st.sp = cur.x; res = cur.x;
            end
            c6502alu_pkg::OP_ORA:
            begin
                t8 = a | v; st.a = t8; st.flags = with_zn(st.flags, t8); res = t8;
            end
            c6502alu_pkg::OP_AND:
            begin
                t8 = a & v; st.a = t8; st.flags = with_zn(st.flags, t8); res = t8;
            end
            c6502alu_pkg::OP_EOR:
            begin
                t8 = a ^ v; st.a = t8; st.flags = with_zn(st.flags, t8); res = t8;
            end
            c6502alu_pkg::OP_BIT:
            begin
                res = a & v;
                st.flags.n = v[7];
                st.flags.v = v[6];
                st.flags.z = (res == 8'h00);
            end
            c6502alu_pkg::OP_ASL_A, c6502alu_pkg::OP_ASL_M:
            begin
                shl_src = (command == c6502alu_pkg::OP_ASL_A) ? a : v;
                t8 = {shl_src[6:0], 1'b0};
                st.flags.c = shl_src[7];
                st.flags = with_zn(st.flags, t8);
                res = t8;
                if (command == c6502alu_pkg::OP_ASL_A)
                begin
                    st.a = t8;
                end
            end
            c6502alu_pkg::OP_LSR_A, c6502alu_pkg::OP_LSR_M:
            begin
                shr_src = (command == c6502alu_pkg::OP_LSR_A) ? a : v;
                t8 = {1'b0, shr_src[7:1]};
                st.flags.c = shr_src[0];
                st.flags = with_zn(st.flags, t8);
                res = t8;
                if (command == c6502alu_pkg::OP_LSR_A)
                begin
                    st.a = t8;
                end
            end
            c6502alu_pkg::OP_ROL_A, c6502alu_pkg::OP_ROL_M:
            begin
                rol_src = (command == c6502alu_pkg::OP_ROL_A) ? a : v;
                t8 = {rol_src[6:0], c_in};
                st.flags.c = rol_src[7];
                st.flags = with_zn(st.flags, t8);
                res = t8;
                if (command == c6502alu_pkg::OP_ROL_A)
                begin
                    st.a = t8;
                end
            end
            c6502alu_pkg::OP_ROR_A, c6502alu_pkg::OP_ROR_M:
            begin
                ror_src = (command == c6502alu_pkg::OP_ROR_A) ? a : v;
                t8 = {c_in, ror_src[7:1]};
                st.flags.c = ror_src[0];
                st.flags = with_zn(st.flags, t8);
                res = t8;
                if (command == c6502alu_pkg::OP_ROR_A)
                begin
                    st.a = t8;
                end
            end
            c6502alu_pkg::OP_INC:
            begin
                t8 = v + 8'd1; st.flags = with_zn(st.flags, t8); res = t8;
            end
            c6502alu_pkg::OP_DEC:
            begin
                t8 = v - 8'd1; st.flags = with_zn(st.flags, t8); res = t8;
            end
            c6502alu_pkg::OP_INX:
            begin
                t8 = cur.x + 8'd1; st.x = t8; st.flags = with_zn(st.flags, t8); res = t8;
            end
            c6502alu_pkg::OP_INY:
            begin
                t8 = cur.y + 8'd1; st.y = t8; st.flags = with_zn(st.flags, t8); res = t8;
            end
            c6502alu_pkg::OP_DEX:
            begin
                t8 = cur.x - 8'd1; st.x = t8; st.flags = with_zn(st.flags, t8); res = t8;
            end
            c6502alu_pkg::OP_DEY:
            begin
                t8 = cur.y - 8'd1; st.y = t8; st.flags = with_zn(st.flags, t8); res = t8;
            end
            c6502alu_pkg::OP_ADC:
            begin
                t8 = adc_t[7:0];
                st.flags.c = |adc_t[9:8];
                st.flags.v = ~(a[7] ^ v[7]) & (a[7] ^ t8[7]);
                st.flags = with_zn(st.flags, t8);
                st.a = t8;
                res = t8;
            end
            c6502alu_pkg::OP_SBC:
            begin
                t8 = sbc_t[7:0];
                st.flags.c = (sbc_t[15:8] == 8'h00);
                st.flags.v = (a[7] ^ t8[7]) & (a[7] ^ v[7]);
                st.flags = with_zn(st.flags, t8);
                st.a = t8;
                res = t8;
            end
            c6502alu_pkg::OP_CMP:
            begin
                st.flags.c = ~cmp_a[8];
                st.flags = with_zn(st.flags, cmp_a[7:0]);
                res = cmp_a[7:0];
            end
            c6502alu_pkg::OP_CPX:
            begin
                st.flags.c = ~cmp_x[8];
                st.flags = with_zn(st.flags, cmp_x[7:0]);
                res = cmp_x[7:0];
            end
            c6502alu_pkg::OP_CPY:
            begin
                st.flags.c = ~cmp_y[8];
                st.flags = with_zn(st.flags, cmp_y[7:0]);
                res = cmp_y[7:0];
            end
            c6502alu_pkg::OP_SEC:
            begin
                st.flags.c = 1'b1; flag_op = 1'b1;
            end
            c6502alu_pkg::OP_CLC:
            begin
                st.flags.c = 1'b0; flag_op = 1'b1;
            end
            c6502alu_pkg::OP_SEI:
            begin
                st.flags.i = 1'b1; flag_op = 1'b1;
            end
            c6502alu_pkg::OP_CLI:
            begin
                st.flags.i = 1'b0; flag_op = 1'b1;
            end
            c6502alu_pkg::OP_SED:
            begin
                st.flags.d = 1'b1; flag_op = 1'b1;
            end
            c6502alu_pkg::OP_CLD:
            begin
                st.flags.d = 1'b0; flag_op = 1'b1;
            end
            c6502alu_pkg::OP_CLV:
            begin
                st.flags.v = 1'b0; flag_op = 1'b1;
            end
            c6502alu_pkg::OP_PHP:
            begin
                flag_op = 1'b1;
            end
            c6502alu_pkg::OP_PLP:
            begin
                // B is kept; the pulled byte loads the rest
                st.flags.n = v[7];
                st.flags.v = v[6];
                st.flags.d = v[3];
                st.flags.i = v[2];
                st.flags.z = v[1];
                st.flags.c = v[0];
                flag_op = 1'b1;
            end
            c6502alu_pkg::OP_LAX:
            begin
                st.a = v; st.x = v; st.flags = with_zn(st.flags, v); res = v;
            end
            c6502alu_pkg::OP_ANC:
            begin
                t8 = a & v;
                st.a = t8;
                st.flags = with_zn(st.flags, t8);
                st.flags.c = t8[7];
                res = t8;
            end
            c6502alu_pkg::OP_SBX:
            begin
                st.x = cmp_ax[7:0];
                st.flags.c = ~cmp_ax[8];
                st.flags = with_zn(st.flags, cmp_ax[7:0]);
                res = cmp_ax[7:0];
            end
            c6502alu_pkg::OP_ARR:
            begin
                if (cur.flags.d)
                begin
                    st.flags.n = c_in;
                    st.flags.z = (arr_sh == 8'h00);
                    st.flags.v = arr_sh[6] ^ arr_and[6];
                    st.flags.c = arr_hi_fix;
                    t8 = arr_res;
                end
                else
                begin
                    st.flags = with_zn(st.flags, arr_sh);
                    st.flags.c = arr_sh[6];
                    st.flags.v = arr_sh[6] ^ arr_sh[5];
                    t8 = arr_sh;
                end
                st.a = t8;
                res = t8;
            end
            c6502alu_pkg::OP_XAA:
            begin
                t8 = (a | ane_constant) & cur.x & v;
                st.a = t8; st.flags = with_zn(st.flags, t8); res = t8;
            end
            c6502alu_pkg::OP_LXA:
            begin
                t8 = (a | c6502alu_pkg::LXA_MAGIC) & v;
                st.a = t8; st.x = t8; st.flags = with_zn(st.flags, t8); res = t8;
            end
            c6502alu_pkg::OP_LAS:
            begin
                t8 = v & cur.sp;
                st.a = t8; st.x = t8; st.sp = t8;
                st.flags = with_zn(st.flags, t8);
                res = t8;
            end
            default:
            begin
                // unused codes leave everything alone and report zero
                res = 8'h00;
            end
        endcase

        if (flag_op)
        begin
            res = c6502alu_pkg::status_byte(st.flags);
        end

        nxt.arch   = st;
        nxt.result = res;
    end

endmodule

// ===== rtl/core/cpu_6502_alu_flags_unit_core.sv =====
// Top level of the 6502 ALU and flag unit: input stage, architectural state, result stage.
//
//  channel   | dir | beat contents (low bit first)                     | handshake
//  ----------+-----+---------------------------------------------------+------------------
//  s_*       | in  | command[5:0], operand[13:6], zero pad [15:14]     | tvalid/tready
//  m_*       | out | result, flags_out, acc_out, x_out, y_out, sp_out  | tvalid/tready
//  APB       | in  | ane_constant at byte address 0                    | psel/penable
//
//  One beat per cycle sustained while m_tready stays high. An accepted beat lands in the
//  input register, executes against A/X/Y/SP/flags, and its result is registered in the
//  result register, from which it shows on m_tdata. Reset (rst_n low, asynchronous) clears
//  A, X, Y, SP and all flags, empties both stages and loads ane_constant with 0xEE. A stall
//  on m_tready holds the result; the input register still takes one more beat, after which
//  s_tready drops until the result is taken.
`timescale 1ns / 1ps

module cpu_6502_alu_flags_unit_core
(
    input  logic                                   clk,
    input  logic                                   rst_n,

    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // [5:0] command, [13:6] operand, [15:14] zero
    input  logic [c6502alu_pkg::S_TDATA_W-1:0]     s_tdata,

    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // [7:0] result, [15:8] flags_out, [23:16] acc_out, [31:24] x_out,
    // [39:32] y_out, [47:40] sp_out
    output logic [c6502alu_pkg::M_TDATA_W-1:0]     m_tdata,

    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [c6502alu_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [c6502alu_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [c6502alu_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                   pready
);

    logic [7:0] ane_constant;

    c6502alu_apb u_apb
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .ane_constant (ane_constant)
    );

    // Input stage
    logic       in_valid_reg;
    logic       in_valid_next;
    logic [5:0] in_cmd_reg;
    logic [5:0] in_cmd_next;
    logic [7:0] in_opnd_reg;
    logic [7:0] in_opnd_next;

    // Architectural state and result stage
    c6502alu_pkg::arch_t    arch_reg;
    c6502alu_pkg::arch_t    arch_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [7:0]             out_result_reg;
    logic [7:0]             out_result_next;

    c6502alu_pkg::alu_out_t alu_nxt;
    logic                   s_beat;
    logic                   exec_fire;

    // Execute when an op is waiting and the result slot is free or draining this cycle.
    assign exec_fire = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || exec_fire;
    assign s_beat    = s_tvalid && s_tready;

    c6502alu_alu u_alu
    (
        .cur          (arch_reg),
        .command      (in_cmd_reg),
        .operand      (in_opnd_reg),
        .ane_constant (ane_constant),
        .nxt          (alu_nxt)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        in_cmd_next   = in_cmd_reg;
        in_opnd_next  = in_opnd_reg;
        if (s_beat)
        begin
            // take the new beat
            in_valid_next = 1'b1;
            in_cmd_next   = s_tdata[5:0];
            in_opnd_next  = s_tdata[13:6];
        end
        else if (exec_fire)
        begin
            // drop the executed op
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        arch_next       = arch_reg;
        out_result_next = out_result_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        if (exec_fire)
        begin
            // advance the state and load the result in the same edge
            arch_next       = alu_nxt.arch;
            out_result_next = alu_nxt.result;
            out_valid_next  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            arch_reg      <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            arch_reg      <= arch_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_cmd_reg     <= in_cmd_next;
        in_opnd_reg    <= in_opnd_next;
        out_result_reg <= out_result_next;
    end

    // The state only moves together with a result load, so the held result beat
    // reports the registers straight from the state.
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {arch_reg.sp, arch_reg.y, arch_reg.x, arch_reg.a,
                       c6502alu_pkg::status_byte(arch_reg.flags), out_result_reg};

    // Every executed op yields a result beat next cycle.
    a_fire_gives_beat: assert property (@(posedge clk) disable iff (!rst_n)
        exec_fire |=> m_tvalid)
        else $error("executed op produced no result beat");

    // State holds unless an op executes.
    a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !exec_fire |=> $stable(arch_reg))
        else $error("architectural state moved without an executed op");

    // No op touches B.
    a_b_flag_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !arch_reg.flags.b)
        else $error("B flag changed");

    // Reported status byte always has bits 4 and 5 set.
    a_status_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[13:12] == 2'b11))
        else $error("status byte padding bits not set");

    // No execute while the result slot is stalled.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready) |-> !exec_fire)
        else $error("result overwritten while stalled");

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the 6502 ALU and flag unit, with stream and APB stimulus.
`timescale 1ns / 1ps

module tb_top;

    // Codes past LAS do nothing to the state and report a zero result.
    localparam logic [5:0] CODE_BASE = 6'd48;
    localparam logic [5:0] CODE_TOP  = 6'd63;

    localparam logic [c6502alu_pkg::APB_ADDR_W-1:0] ANE_ADDR =
        {c6502alu_pkg::REG_ANE_CONSTANT, 2'b00};

    localparam int N_DIR           = 28;
    localparam int N_PHASES        = 6;
    localparam int ITEMS_PER_PHASE = 240;

    typedef struct {
        logic [5:0]  code;
        logic [7:0]  opnd;
        bit          known;
        logic [47:0] want;  // {sp, y, x, a, flags, result}
    } vector_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                                s_tvalid = 1'b0;
    logic                                s_tready;
    // [5:0] command, [13:6] operand, [15:14] zero
    logic [c6502alu_pkg::S_TDATA_W-1:0]  s_tdata = '0;

    logic                                m_tvalid;
    logic                                m_tready = 1'b0;
    // [7:0] result, [15:8] flags_out, [23:16] acc_out, [31:24] x_out,
    // [39:32] y_out, [47:40] sp_out
    logic [c6502alu_pkg::M_TDATA_W-1:0]  m_tdata;

    logic                                psel = 1'b0;
    logic                                penable = 1'b0;
    logic                                pwrite = 1'b0;
    logic [c6502alu_pkg::APB_ADDR_W-1:0] paddr = '0;
    logic [c6502alu_pkg::APB_DATA_W-1:0] pwdata = '0;
    logic [c6502alu_pkg::APB_DATA_W-1:0] prdata;
    logic                                pready;

    // Architectural state as the testbench expects it to evolve.
    logic [7:0]           reg_a = 8'h00;
    logic [7:0]           reg_x = 8'h00;
    logic [7:0]           reg_y = 8'h00;
    logic [7:0]           reg_sp = 8'h00;
    c6502alu_pkg::flags_t st = '0;
    logic [7:0]           ane_shadow = c6502alu_pkg::ANE_CONSTANT_RESET;

    logic [47:0] pending_results [$];
    int          n_errors = 0;
    bit          src_burst = 1'b0;
    bit          snk_burst = 1'b0;

    string fld_name [6] = '{"result", "flags_out", "acc_out", "x_out", "y_out", "sp_out"};

    // Directed rows: reset values, flag packing, unused codes, decimal-mode corners
    // of ADC, SBC and ARR, ROL flags and the illegal ops. Rows with known set carry
    // an expected beat typed in by hand; the rest take the predicted one.
    vector_t dir_vec [N_DIR] = '{
        '{c6502alu_pkg::OP_PHP,   8'h00, 1'b1, 48'h000000003030},  // flags out of reset
        '{c6502alu_pkg::OP_LDA,   8'h00, 1'b1, 48'h000000003200},
        '{c6502alu_pkg::OP_LDA,   8'hFF, 1'b1, 48'h000000FFB0FF},
        '{CODE_TOP,               8'hA5, 1'b1, 48'h000000FFB000},  // unused code
        '{c6502alu_pkg::OP_PLP,   8'hFF, 1'b1, 48'h000000FFFFFF},  // B not loaded by PLP
        '{c6502alu_pkg::OP_PLP,   8'h00, 1'b1, 48'h000000FF3030},
        '{c6502alu_pkg::OP_SED,   8'h00, 1'b0, 48'h0},
        '{c6502alu_pkg::OP_LDA,   8'h58, 1'b0, 48'h0},
        '{c6502alu_pkg::OP_ADC,   8'h46, 1'b0, 48'h0},  // both nibbles need fixing
        '{c6502alu_pkg::OP_ADC,   8'h99, 1'b0, 48'h0},
        '{c6502alu_pkg::OP_SBC,   8'h99, 1'b0, 48'h0},
        '{c6502alu_pkg::OP_LDA,   8'hF5, 1'b0, 48'h0},
        '{c6502alu_pkg::OP_ARR,   8'hFF, 1'b0, 48'h0},  // decimal ARR, high nibble fixed
        '{c6502alu_pkg::OP_SEC,   8'h00, 1'b0, 48'h0},
        '{c6502alu_pkg::OP_ARR,   8'h5A, 1'b0, 48'h0},  // decimal ARR, carry into N
        '{c6502alu_pkg::OP_CLD,   8'h00, 1'b0, 48'h0},
        '{c6502alu_pkg::OP_ARR,   8'hC0, 1'b0, 48'h0},  // binary ARR
        '{c6502alu_pkg::OP_ROL_A, 8'h00, 1'b0, 48'h0},
        '{c6502alu_pkg::OP_LDX,   8'h80, 1'b0, 48'h0},
        '{c6502alu_pkg::OP_XAA,   8'hFF, 1'b0, 48'h0},
        '{c6502alu_pkg::OP_LXA,   8'h7F, 1'b0, 48'h0},
        '{c6502alu_pkg::OP_TXS,   8'h00, 1'b0, 48'h0},
        '{c6502alu_pkg::OP_LAS,   8'hFF, 1'b0, 48'h0},
        '{c6502alu_pkg::OP_BIT,   8'hC0, 1'b0, 48'h0},
        '{c6502alu_pkg::OP_CMP,   8'h80, 1'b0, 48'h0},
        '{c6502alu_pkg::OP_DEY,   8'h00, 1'b0, 48'h0},  // Y wraps to FF
        '{c6502alu_pkg::OP_INC,   8'hFF, 1'b0, 48'h0},
        '{CODE_BASE,              8'h00, 1'b0, 48'h0}
    };

    cpu_6502_alu_flags_unit_core DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #6 clk = ~clk;

    function automatic void set_zn(input logic [7:0] v);
        st.z = (v == 8'h00);
        st.n = v[7];
    endfunction

    // Shared by CMP, CPX, CPY and SBX: C means no borrow.
    function automatic logic [7:0] compare_to(input logic [7:0] lhs, input logic [7:0] rhs);
        logic [7:0] diff;
        diff = lhs - rhs;
        st.c = (lhs >= rhs);
        set_zn(diff);
        return diff;
    endfunction

    // Apply one operation to the expected state and return the beat it should produce.
    function automatic logic [47:0] execute_op(input logic [5:0] code, input logic [7:0] opnd);
        int unsigned ua;
        int unsigned uv;
        int unsigned t;
        int unsigned cin;
        int unsigned u_and;
        logic [7:0]  src;
        logic [7:0]  r;
        logic [7:0]  sbyte;
        logic        acc_form;
        logic        flag_op;
        ua       = reg_a;
        uv       = opnd;
        cin      = st.c;
        r        = 8'h00;
        flag_op  = 1'b0;
        acc_form = (code == c6502alu_pkg::OP_ASL_A) || (code == c6502alu_pkg::OP_LSR_A) ||
                   (code == c6502alu_pkg::OP_ROL_A) || (code == c6502alu_pkg::OP_ROR_A);
        src      = acc_form ? reg_a : opnd;
        case (code)
            c6502alu_pkg::OP_LDA: begin reg_a = opnd; set_zn(opnd); r = opnd; end
            c6502alu_pkg::OP_LDX: begin reg_x = opnd; set_zn(opnd); r = opnd; end
            c6502alu_pkg::OP_LDY: begin reg_y = opnd; set_zn(opnd); r = opnd; end
            c6502alu_pkg::OP_TAX: begin reg_x = reg_a; set_zn(reg_x); r = reg_x; end
            c6502alu_pkg::OP_TAY: begin reg_y = reg_a; set_zn(reg_y); r = reg_y; end
            c6502alu_pkg::OP_TXA: begin reg_a = reg_x; set_zn(reg_a); r = reg_a; end
            c6502alu_pkg::OP_TYA: begin reg_a = reg_y; set_zn(reg_a); r = reg_a; end
            c6502alu_pkg::OP_TSX: begin reg_x = reg_sp; set_zn(reg_x); r = reg_x; end
            c6502alu_pkg::OP_TXS: begin reg_sp = reg_x; r = reg_sp; end
            c6502alu_pkg::OP_ORA: begin reg_a = reg_a | opnd; set_zn(reg_a); r = reg_a; end
            c6502alu_pkg::OP_AND: begin reg_a = reg_a & opnd; set_zn(reg_a); r = reg_a; end
            c6502alu_pkg::OP_EOR: begin reg_a = reg_a ^ opnd; set_zn(reg_a); r = reg_a; end
            c6502alu_pkg::OP_BIT:
            begin
                st.n = opnd[7];
                st.v = opnd[6];
                r    = opnd & reg_a;
                st.z = (r == 8'h00);
            end
            c6502alu_pkg::OP_ASL_A, c6502alu_pkg::OP_ASL_M:
            begin
                r = {src[6:0], 1'b0};
                st.c = src[7];
                set_zn(r);
            end
            c6502alu_pkg::OP_LSR_A, c6502alu_pkg::OP_LSR_M:
            begin
                r = {1'b0, src[7:1]};
                st.c = src[0];
                set_zn(r);
            end
            c6502alu_pkg::OP_ROL_A, c6502alu_pkg::OP_ROL_M:
            begin
                r = {src[6:0], st.c};
                st.c = src[7];
                set_zn(r);
            end
            c6502alu_pkg::OP_ROR_A, c6502alu_pkg::OP_ROR_M:
            begin
                r = {st.c, src[7:1]};
                st.c = src[0];
                set_zn(r);
            end
            c6502alu_pkg::OP_INC: begin r = opnd + 8'd1; set_zn(r); end
            c6502alu_pkg::OP_DEC: begin r = opnd - 8'd1; set_zn(r); end
            c6502alu_pkg::OP_INX: begin reg_x = reg_x + 8'd1; set_zn(reg_x); r = reg_x; end
            c6502alu_pkg::OP_INY: begin reg_y = reg_y + 8'd1; set_zn(reg_y); r = reg_y; end
            c6502alu_pkg::OP_DEX: begin reg_x = reg_x - 8'd1; set_zn(reg_x); r = reg_x; end
            c6502alu_pkg::OP_DEY: begin reg_y = reg_y - 8'd1; set_zn(reg_y); r = reg_y; end
            c6502alu_pkg::OP_ADC:
            begin
                if (st.d)
                begin
                    // Correct the low nibble first, then the high one on the summed byte.
                    t = (ua & 'hF) + (uv & 'hF) + cin;
                    if (t > 'h9) t = t + 'h6;
                    t = t + (ua & 'hF0) + (uv & 'hF0);
                    if ((t & 'h1F0) > 'h90) t = t + 'h60;
                end
                else
                begin
                    t = ua + uv + cin;
                end
                st.c = (t > 'hFF);
                t    = t & 'hFF;
                st.v = (((ua ^ uv) & 'h80) == 0) && (((ua ^ t) & 'h80) != 0);
                r    = t[7:0];
                set_zn(r);
                reg_a = r;
            end
            c6502alu_pkg::OP_SBC:
            begin
                if (st.d)
                begin
                    // Borrow out of the low nibble pulls 0x10 from the high part.
                    t = ((ua & 'hF) - (uv & 'hF) - (1 - cin)) & 'hFFFF;
                    if ((t & 'h10) != 0)
                        t = ((t - 'h6) & 'hF) | (((ua & 'hF0) - (uv & 'hF0) - 'h10) & 'hFFFF);
                    else
                        t = (t & 'hF) | (((ua & 'hF0) - (uv & 'hF0)) & 'hFFFF);
                    t = t & 'hFFFF;
                    if ((t & 'h100) != 0) t = (t - 'h60) & 'hFFFF;
                end
                else
                begin
                    t = (ua - uv - (1 - cin)) & 'hFFFF;
                end
                st.c = (t < 'h100);
                t    = t & 'hFF;
                st.v = (((ua ^ t) & 'h80) != 0) && (((ua ^ uv) & 'h80) != 0);
                r    = t[7:0];
                set_zn(r);
                reg_a = r;
            end
            c6502alu_pkg::OP_CMP: r = compare_to(reg_a, opnd);
            c6502alu_pkg::OP_CPX: r = compare_to(reg_x, opnd);
            c6502alu_pkg::OP_CPY: r = compare_to(reg_y, opnd);
            c6502alu_pkg::OP_SEC: begin st.c = 1'b1; flag_op = 1'b1; end
            c6502alu_pkg::OP_CLC: begin st.c = 1'b0; flag_op = 1'b1; end
            c6502alu_pkg::OP_SEI: begin st.i = 1'b1; flag_op = 1'b1; end
            c6502alu_pkg::OP_CLI: begin st.i = 1'b0; flag_op = 1'b1; end
            c6502alu_pkg::OP_SED: begin st.d = 1'b1; flag_op = 1'b1; end
            c6502alu_pkg::OP_CLD: begin st.d = 1'b0; flag_op = 1'b1; end
            c6502alu_pkg::OP_CLV: begin st.v = 1'b0; flag_op = 1'b1; end
            c6502alu_pkg::OP_PHP: flag_op = 1'b1;
            c6502alu_pkg::OP_PLP:
            begin
                // B survives; every other flag comes from the pulled byte.
                st.c = opnd[0];
                st.z = opnd[1];
                st.i = opnd[2];
                st.d = opnd[3];
                st.v = opnd[6];
                st.n = opnd[7];
                flag_op = 1'b1;
            end
            c6502alu_pkg::OP_LAX:
            begin
                reg_a = opnd; reg_x = opnd; set_zn(opnd); r = opnd;
            end
            c6502alu_pkg::OP_ANC:
            begin
                reg_a = reg_a & opnd;
                set_zn(reg_a);
                st.c = st.n;
                r = reg_a;
            end
            c6502alu_pkg::OP_SBX:
            begin
                reg_x = compare_to(reg_a & reg_x, opnd); r = reg_x;
            end
            c6502alu_pkg::OP_ARR:
            begin
                u_and = ua & uv;
                t     = (u_and | (cin << 8)) >> 1;
                if (st.d)
                begin
                    // N, Z and V come from the plain shift; the nibble fixes then set C.
                    st.n = st.c;
                    st.z = (t == 0);
                    st.v = ((t ^ u_and) & 'h40) != 0;
                    if ((u_and & 'hF) + (u_and & 'h1) > 'h5)
                        t = (t & 'hF0) | ((t + 'h6) & 'hF);
                    if ((u_and & 'hF0) + (u_and & 'h10) > 'h50)
                    begin
                        t = (t & 'h0F) | ((t + 'h60) & 'hF0);
                        st.c = 1'b1;
                    end
                    else
                    begin
                        st.c = 1'b0;
                    end
                end
                else
                begin
                    set_zn(t[7:0]);
                    st.c = t[6];
                    st.v = t[6] ^ t[5];
                end
                r = t[7:0];
                reg_a = r;
            end
            c6502alu_pkg::OP_XAA:
            begin
                reg_a = (reg_a | ane_shadow) & reg_x & opnd;
                set_zn(reg_a);
                r = reg_a;
            end
            c6502alu_pkg::OP_LXA:
            begin
                reg_a = (reg_a | c6502alu_pkg::LXA_MAGIC) & opnd;
                reg_x = reg_a;
                set_zn(reg_a);
                r = reg_a;
            end
            c6502alu_pkg::OP_LAS:
            begin
                r = opnd & reg_sp;
                reg_a = r;
                reg_x = r;
                reg_sp = r;
                set_zn(r);
            end
            default: ;
        endcase
        if (acc_form) reg_a = r;
        sbyte = {st.n, st.v, 2'b11, st.d, st.i, st.z, st.c};
        if (flag_op) r = sbyte;
        return {reg_sp, reg_y, reg_x, reg_a, sbyte, r};
    endfunction

    // Present one command beat after a random gap; predict it once it is taken.
    task automatic send_beat(input logic [5:0] code, input logic [7:0] opnd,
                             input bit known, input logic [47:0] want);
        int          gap;
        logic [47:0] pred;
        if ($urandom_range(0, 63) == 0) src_burst = !src_burst;
        gap = src_burst ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, opnd, code};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        pred = execute_op(code, opnd);
        pending_results.push_back(known ? want : pred);
    endtask

    // Drop valid and hold until every result beat has drained.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Setup cycle, then access cycle; the register takes the value at the access edge.
    task automatic write_ane(input logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ANE_ADDR;
        pwdata  <= {24'h000000, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        ane_shadow = value;
    endtask

    // Result side: stall at random, then compare each taken beat field by field
    // against the oldest prediction.
    initial
    begin
        int          stall;
        logic [47:0] want;
        logic [47:0] got;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 63) == 0) snk_burst = !snk_burst;
            stall = snk_burst ? 0 : $urandom_range(0, 15);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
            got = m_tdata;
            if (pending_results.size() == 0)
            begin
                n_errors++;
                if (n_errors < 40)
                    $display("%0t: result beat with nothing expected, expected none, got %012h",
                             $time, got);
            end
            else
            begin
                want = pending_results.pop_front();
                for (int i = 0; i < 6; i++)
                begin
                    if (got[8*i +: 8] !== want[8*i +: 8])
                    begin
                        n_errors++;
                        if (n_errors < 40)
                            $display("%0t: %s expected %02h, got %02h", $time, fld_name[i],
                                     want[8*i +: 8], got[8*i +: 8]);
                    end
                end
            end
        end
    end

    // Stimulus: directed rows at the reset value of the ANE byte, then random
    // phases, each under a fresh ANE byte written while the unit is idle.
    initial
    begin
        logic [5:0] code;
        logic [7:0] opnd;
        logic [7:0] ane_value;
        int         n_real;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        for (int k = 0; k < N_DIR; k++)
            send_beat(dir_vec[k].code, dir_vec[k].opnd, dir_vec[k].known, dir_vec[k].want);

        for (int p = 0; p < N_PHASES; p++)
        begin
            drain_results();
            if (p == 0)
                ane_value = 8'h00;
            else if (p == 1)
                ane_value = 8'hFF;
            else
                ane_value = 8'($urandom_range(0, 255));
            write_ane(ane_value);

            // Unused codes go in now and then but do not count toward the phase.
            n_real = 0;
            while (n_real < ITEMS_PER_PHASE)
            begin
                if ($urandom_range(0, 9) == 0)
                    code = 6'($urandom_range(CODE_BASE, CODE_TOP));
                else
                    code = 6'($urandom_range(0, c6502alu_pkg::OP_LAS));
                case ($urandom_range(0, 7))
                    0:
                    begin
                        case ($urandom_range(0, 3))
                            0: opnd = 8'h00;
                            1: opnd = 8'hFF;
                            2: opnd = 8'h80;
                            default: opnd = 8'h7F;
                        endcase
                    end
                    // Valid BCD bytes keep decimal arithmetic on its usual path.
                    1, 2: opnd = {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
                    default: opnd = 8'($urandom);
                endcase
                send_beat(code, opnd, 1'b0, 48'h0);
                if (code <= c6502alu_pkg::OP_LAS) n_real++;
            end
        end

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (n_errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run with every gap and stall at its maximum.
    initial
    begin
        #5000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
